[sv/slcg_pkg.sv]
// shared types and constants for the single-linkage clustering gap block
`timescale 1ns / 1ps
package slcg_pkg;

  localparam int unsigned CoordW  = 14;
  localparam int unsigned DistW   = 29;
  localparam int unsigned KW      = 11;
  localparam int unsigned StatW   = 2;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

  localparam logic [StatW-1:0] StatOk       = 2'd0;
  localparam logic [StatW-1:0] StatFewPts   = 2'd1;
  localparam logic [StatW-1:0] StatDropped  = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_PINIT,
    S_SCAN,
    S_DRAIN,
    S_MARK,
    S_SELC,
    S_SELW,
    S_SELS,
    S_SELD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load_we;
    logic load_clear;
    logic prim_start;
    logic scan_start;
    logic scan_run;
    logic mark;
    logic sel_start;
    logic sel_latch;
    logic sel_run;
    logic sel_next;
    logic res_err;
    logic res_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic k_ok;
    logic scan_issued;
    logic pipe_empty;
    logic last_round;
    logic sel_issued;
    logic sel_empty;
    logic sel_hit;
  } dp_stat_t;

endpackage

[sv/single_linkage_cluster_gap.sv]
// points load one word per cycle; after the last point, a prim scan builds the spanning tree
// the tree takes n-1 scans of the n points through the read and square pipeline, and rank
// selection then tests the n-1 tree edges as candidates in turn
// throughput: one point per cycle while loading; one result per point set
// reset: async active low; clears counts and flags, cluster_count returns to 2
// point, distance and edge stores are not cleared and are only read below the count
`timescale 1ns / 1ps
module single_linkage_cluster_gap
  import slcg_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // coord_x[13:0], coord_y[27:14], zero
  input  logic                s_axis_tlast,   // last_point
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // gap_squared[28:0], status[30:29], zero
  input  logic                cfg_we_i,
  input  logic [KW-1:0]       cfg_data_i
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [DistW-1:0] gap;
  logic [StatW-1:0] status;

  slcg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid)
  );

  slcg_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .coord_x_i  (s_axis_tdata[CoordW-1:0]),
    .coord_y_i  (s_axis_tdata[2*CoordW-1:CoordW]),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .gap_o      (gap),
    .status_o   (status)
  );

  assign m_axis_tdata = {1'b0, status, gap};

endmodule

[sv/slcg_ctrl.sv]
// sequencer for loading, spanning-tree build and edge rank selection
`timescale 1ns / 1ps
module slcg_ctrl
  import slcg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  input  logic     s_last_i,
  input  logic     m_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     s_ready_o,
  output logic     m_valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_we = 1'b1;
          if (s_last_i) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.k_ok) begin
          state_d = S_PINIT;
        end else begin
          cmd_o.res_err = 1'b1;
          state_d       = S_OUT;
        end
      end
      S_PINIT: begin
        cmd_o.prim_start = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_issued) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat_i.pipe_empty) state_d = S_MARK;
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (stat_i.last_round) begin
          cmd_o.sel_start = 1'b1;
          state_d         = S_SELC;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SELC: begin
        // candidate read is issued here
        state_d = S_SELW;
      end
      S_SELW: begin
        cmd_o.sel_latch = 1'b1;
        state_d         = S_SELS;
      end
      S_SELS: begin
        cmd_o.sel_run = 1'b1;
        if (stat_i.sel_issued) state_d = S_SELD;
      end
      S_SELD: begin
        if (stat_i.sel_empty) begin
          if (stat_i.sel_hit) begin
            cmd_o.res_ok = 1'b1;
            state_d      = S_OUT;
          end else begin
            cmd_o.sel_next = 1'b1;
            state_d        = S_SELC;
          end
        end
      end
      S_OUT: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          cmd_o.load_clear = 1'b1;
          state_d          = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

endmodule

[sv/slcg_dp.sv]
// point stores, prim scan pipeline, edge store and rank counting
`timescale 1ns / 1ps
module slcg_dp
  import slcg_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic [CoordW-1:0] coord_x_i,
  input  logic [CoordW-1:0] coord_y_i,
  input  logic              cfg_we_i,
  input  logic [KW-1:0]     cfg_data_i,
  output logic [DistW-1:0]  gap_o,
  output logic [StatW-1:0]  status_o
);

  localparam int unsigned AW   = $clog2(MAX_POINTS);
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned CMPW = (CW > KW) ? CW : KW;
  localparam int unsigned SqW  = 2 * CoordW;

  logic [CoordW-1:0] px_mem [MAX_POINTS];
  logic [CoordW-1:0] py_mem [MAX_POINTS];
  logic [DistW-1:0]  best_mem [MAX_POINTS];
  logic              tree_mem [MAX_POINTS];
  logic [DistW-1:0]  edge_mem [MAX_POINTS];

  logic [KW-1:0]     k_q;
  logic [CW-1:0]     cnt_q;
  logic              ovf_q;
  logic [CW-1:0]     j_q, round_q, i_q;
  logic              first_q;
  logic [CoordW-1:0] pick_x_q, pick_y_q;
  logic [DistW-1:0]  min_d_q;
  logic [AW-1:0]     min_idx_q;
  logic [CoordW-1:0] min_x_q, min_y_q;
  logic              min_found_q;

  // stage 1: registered memory reads
  logic              rd_v_q;
  logic [AW-1:0]     rd_j_q;
  logic [CoordW-1:0] rx_q, ry_q;
  logic [DistW-1:0]  rb_q;
  logic              rit_q;
  // stage 2: squares
  logic              s2_v_q;
  logic [AW-1:0]     s2_j_q;
  logic [SqW-1:0]    sqx_q, sqy_q;
  logic [DistW-1:0]  s2_b_q;
  logic              s2_it_q;
  logic [CoordW-1:0] s2_x_q, s2_y_q;

  // selection
  logic [DistW-1:0]  er_q;
  logic              e_v_q;
  logic [DistW-1:0]  cand_q;
  logic [CW-1:0]     less_q, leq_q;
  logic [DistW-1:0]  gap_q;
  logic [StatW-1:0]  status_q;

  logic              issue;
  logic [AW-1:0]     eaddr;
  logic [CoordW-1:0] dx, dy;
  logic [DistW-1:0]  dsq, eff_b, nb;
  logic              eff_it;
  logic [CW-1:0]     m_edges, rank;
  logic              sel_issue;

  assign issue     = cmd_i.scan_run && (j_q != cnt_q);
  assign m_edges   = cnt_q - CW'(1);
  assign rank      = CW'(CMPW'(cnt_q) - CMPW'(k_q));
  assign sel_issue = cmd_i.sel_run && (j_q != m_edges);
  assign eaddr     = cmd_i.sel_run ? j_q[AW-1:0] : i_q[AW-1:0];

  assign dx = (rx_q > pick_x_q) ? rx_q - pick_x_q : pick_x_q - rx_q;
  assign dy = (ry_q > pick_y_q) ? ry_q - pick_y_q : pick_y_q - ry_q;

  // first round: tree holds only point 0, all distances start infinite
  assign dsq    = DistW'(sqx_q) + DistW'(sqy_q);
  assign eff_it = first_q ? (s2_j_q == '0) : s2_it_q;
  assign eff_b  = first_q ? '1 : s2_b_q;
  assign nb     = (dsq < eff_b) ? dsq : eff_b;

  assign stat_o.k_ok        = (k_q >= KW'(2)) && (CMPW'(k_q) <= CMPW'(cnt_q));
  assign stat_o.scan_issued = (j_q == cnt_q);
  assign stat_o.pipe_empty  = !rd_v_q && !s2_v_q;
  assign stat_o.last_round  = (round_q == cnt_q - CW'(2));
  assign stat_o.sel_issued  = (j_q == m_edges);
  assign stat_o.sel_empty   = !e_v_q;
  assign stat_o.sel_hit     = (less_q <= rank) && (rank < leq_q);

  assign gap_o    = gap_q;
  assign status_o = status_q;

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && (cnt_q != CW'(MAX_POINTS))) begin
      px_mem[cnt_q[AW-1:0]] <= coord_x_i;
      py_mem[cnt_q[AW-1:0]] <= coord_y_i;
    end
    rx_q  <= px_mem[j_q[AW-1:0]];
    ry_q  <= py_mem[j_q[AW-1:0]];
    rb_q  <= best_mem[j_q[AW-1:0]];
    rit_q <= tree_mem[j_q[AW-1:0]];
    if (s2_v_q) best_mem[s2_j_q] <= nb;
    if (s2_v_q) begin
      tree_mem[s2_j_q] <= eff_it;
    end else if (cmd_i.mark) begin
      tree_mem[min_idx_q] <= 1'b1;
    end
    if (cmd_i.mark) edge_mem[round_q[AW-1:0]] <= min_d_q;
    er_q <= edge_mem[eaddr];
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    rd_j_q  <= j_q[AW-1:0];
    sqx_q   <= SqW'(dx) * SqW'(dx);
    sqy_q   <= SqW'(dy) * SqW'(dy);
    s2_b_q  <= rb_q;
    s2_it_q <= rit_q;
    s2_j_q  <= rd_j_q;
    s2_x_q  <= rx_q;
    s2_y_q  <= ry_q;
    if (cmd_i.sel_latch) cand_q <= er_q;
    if (cmd_i.res_err) begin
      gap_q    <= '0;
      status_q <= StatFewPts;
    end else if (cmd_i.res_ok) begin
      gap_q    <= cand_q;
      status_q <= ovf_q ? StatDropped : StatOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= KW'(2);
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      j_q         <= '0;
      round_q     <= '0;
      i_q         <= '0;
      first_q     <= 1'b0;
      pick_x_q    <= '0;
      pick_y_q    <= '0;
      min_d_q     <= '0;
      min_idx_q   <= '0;
      min_x_q     <= '0;
      min_y_q     <= '0;
      min_found_q <= 1'b0;
      rd_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      e_v_q       <= 1'b0;
      less_q      <= '0;
      leq_q       <= '0;
    end else begin
      if (cfg_we_i) k_q <= cfg_data_i;
      if (cmd_i.load_we) begin
        if (cnt_q != CW'(MAX_POINTS)) begin
          cnt_q <= cnt_q + CW'(1);
          // point 0 seeds the tree
          if (cnt_q == '0) begin
            pick_x_q <= coord_x_i;
            pick_y_q <= coord_y_i;
          end
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.load_clear) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
      if (cmd_i.prim_start) begin
        round_q <= '0;
        first_q <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        j_q         <= '0;
        min_found_q <= 1'b0;
      end else if (issue || sel_issue) begin
        j_q <= j_q + CW'(1);
      end else if (cmd_i.sel_latch) begin
        j_q <= '0;
      end
      rd_v_q <= issue;
      s2_v_q <= rd_v_q;
      if (s2_v_q && !eff_it && (!min_found_q || nb < min_d_q)) begin
        min_found_q <= 1'b1;
        min_d_q     <= nb;
        min_idx_q   <= s2_j_q;
        min_x_q     <= s2_x_q;
        min_y_q     <= s2_y_q;
      end
      if (cmd_i.mark) begin
        round_q  <= round_q + CW'(1);
        first_q  <= 1'b0;
        pick_x_q <= min_x_q;
        pick_y_q <= min_y_q;
      end
      if (cmd_i.sel_start) begin
        i_q <= '0;
      end else if (cmd_i.sel_next) begin
        i_q <= i_q + CW'(1);
      end
      // rank of candidate among all tree edges
      e_v_q <= sel_issue;
      if (cmd_i.sel_latch) begin
        less_q <= '0;
        leq_q  <= '0;
      end else if (e_v_q) begin
        if (er_q < cand_q) less_q <= less_q + CW'(1);
        if (er_q <= cand_q) leq_q <= leq_q + CW'(1);
      end
    end
  end

endmodule

[verif/single_linkage_cluster_gap_tb.sv]
// testbench for the single-linkage clustering gap block with its own spanning tree predictor
`timescale 1ns / 1ps
module single_linkage_cluster_gap_tb
  import slcg_pkg::*;
();

  localparam int unsigned MaxPts = 1024;
  localparam int unsigned CoordMax = (1 << CoordW) - 1;

  typedef struct packed {
    logic [DistW-1:0] gap;
    logic [StatW-1:0] status;
  } gap_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [KW-1:0]       cfg_data_i;

  single_linkage_cluster_gap #(.MAX_POINTS(MaxPts)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_data_i
  );

  // predictor state
  logic [CoordW-1:0] pt_x [MaxPts];
  logic [CoordW-1:0] pt_y [MaxPts];
  int unsigned       pt_count;
  bit                pt_dropped;
  logic [KW-1:0]     cluster_k;

  gap_result_t gap_queue[$];
  int unsigned errors;
  int unsigned sets_sent, points_sent, results_seen;
  bit          send_gaps, recv_gaps;
  int unsigned stall_seq, stall_len;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("timeout at %0t", $time);
    $display("single_linkage_cluster_gap_tb failed");
    $finish;
  end

  function automatic logic [DistW-1:0] dist_sq(int unsigned a, int unsigned b);
    int unsigned dx, dy;
    dx = pt_x[a] > pt_x[b] ? pt_x[a] - pt_x[b] : pt_x[b] - pt_x[a];
    dy = pt_y[a] > pt_y[b] ? pt_y[a] - pt_y[b] : pt_y[b] - pt_y[a];
    return DistW'(dx * dx + dy * dy);
  endfunction

  // prim over the stored points, then the (n-k+1)-th smallest tree edge
  function automatic gap_result_t predict_gap();
    gap_result_t r;
    int unsigned best [MaxPts];
    bit          used [MaxPts];
    int unsigned tree_w[$];
    int unsigned n, pick, d;
    n = pt_count;
    r.gap = '0;
    if (cluster_k < 2 || cluster_k > n) begin
      r.status = StatFewPts;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      used[i] = 1'b0;
      best[i] = dist_sq(0, i);
    end
    used[0] = 1'b1;
    for (int m = 0; m + 1 < n; m++) begin
      pick = n;
      for (int j = 0; j < n; j++)
        if (!used[j] && (pick == n || best[j] < best[pick])) pick = j;
      used[pick] = 1'b1;
      tree_w = {tree_w, best[pick]};
      for (int j = 0; j < n; j++) begin
        if (!used[j]) begin
          d = dist_sq(pick, j);
          if (d < best[j]) best[j] = d;
        end
      end
    end
    tree_w.sort();
    r.gap = DistW'(tree_w[n - cluster_k]);
    r.status = pt_dropped ? StatDropped : StatOk;
    return r;
  endfunction

  // sends one point; valid stays high across back-to-back words
  task automatic send_point(input int unsigned x, input int unsigned y, input bit last);
    gap_result_t pred;
    while (send_gaps && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - 2 * CoordW){1'b0}}, CoordW'(y), CoordW'(x)};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    points_sent++;
    if (pt_count < MaxPts) begin
      pt_x[pt_count] = CoordW'(x);
      pt_y[pt_count] = CoordW'(y);
      pt_count++;
    end else begin
      pt_dropped = 1'b1;
    end
    if (last) begin
      pred = predict_gap();
      gap_queue = {gap_queue, pred};
      pt_count = 0;
      pt_dropped = 1'b0;
      sets_sent++;
    end
  endtask

  task automatic send_random_set(input int unsigned n, input int unsigned span);
    for (int i = 0; i < n; i++)
      send_point($urandom_range(span), $urandom_range(span), i == n - 1);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    while (gap_queue.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_clusters(input int unsigned k);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= KW'(k);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cluster_k = KW'(k);
    @(posedge clk_i);
  endtask

  // corners of the coordinate range, duplicates, k at the edges
  task automatic test_directed();
    send_point(CoordMax, CoordMax, 1'b1);          // one point, k of two
    send_point(0, 0, 1'b0);
    send_point(CoordMax, CoordMax, 1'b1);          // largest gap
    send_point(CoordMax, 0, 1'b0);
    send_point(0, CoordMax, 1'b0);
    send_point(CoordMax, 0, 1'b1);                 // duplicate point
    set_clusters(3);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b1);                        // k equals n, all distances zero
    send_point(0, 0, 1'b0);
    send_point(3, 4, 1'b0);
    send_point(6, 8, 1'b0);
    send_point(100, 100, 1'b1);                    // tie between tree edges
    set_clusters(0);
    send_random_set(4, CoordMax);
    set_clusters(1);
    send_random_set(4, CoordMax);
    set_clusters(2047);
    send_random_set(3, CoordMax);
  endtask

  // more points than the store holds; the last point itself is dropped
  task automatic test_capacity();
    set_clusters(1024);
    send_random_set(MaxPts + 3, CoordMax);
  endtask

  // receiver holds off while the sender keeps offering sets
  task automatic test_backpressure();
    set_clusters(2);
    stall_len = 3000;
    stall_seq++;
    for (int s = 0; s < 8; s++) send_random_set($urandom_range(2, 10), CoordMax);
    drain_results();
  endtask

  task automatic test_random(input int unsigned budget);
    int unsigned n, span, k;
    while (points_sent < budget) begin
      k = $urandom_range(99) < 10 ? $urandom_range(2047) : $urandom_range(2, 12);
      set_clusters(k);
      repeat ($urandom_range(2, 6)) begin
        n = $urandom_range(99) < 15 ? $urandom_range(1, 3) : $urandom_range(2, 24);
        span = $urandom_range(1) ? CoordMax : $urandom_range(1, 20);
        send_random_set(n, span);
      end
    end
  endtask

  task automatic test_no_gaps();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    set_clusters(3);
    for (int s = 0; s < 10; s++) send_random_set($urandom_range(3, 20), CoordMax);
    drain_results();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // receiver side: random ready with long stalls on request
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned seen_seq, stall_left;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      seen_seq = 0;
      stall_left = 0;
    end else begin
      if (seen_seq != stall_seq) begin
        seen_seq = stall_seq;
        stall_left = stall_len;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(recv_gaps && $urandom_range(99) < 29);
      end
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    gap_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (gap_queue.size() == 0) begin
        $display("%0t: unexpected result gap %0d status %0d", $time,
                 m_axis_tdata[DistW-1:0], m_axis_tdata[DistW+StatW-1:DistW]);
        errors++;
      end else begin
        exp_r = gap_queue.pop_front();
        if (m_axis_tdata[DistW-1:0] !== exp_r.gap) begin
          $display("%0t: gap expected %0d actual %0d", $time, exp_r.gap,
                   m_axis_tdata[DistW-1:0]);
          errors++;
        end
        if (m_axis_tdata[DistW+StatW-1:DistW] !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   m_axis_tdata[DistW+StatW-1:DistW]);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    pt_count = 0;
    pt_dropped = 1'b0;
    cluster_k = KW'(2);
    errors = 0;
    sets_sent = 0;
    points_sent = 0;
    results_seen = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    stall_seq = 0;
    stall_len = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_no_gaps();
    test_backpressure();
    test_capacity();
    test_random(1800);
    drain_results();
    repeat (50) @(posedge clk_i);

    $display("covered %0d point sets from %0d points, %0d results checked", sets_sent,
             points_sent, results_seen);
    $display("included k extremes, too few points, store overflow and long output stalls");
    if (errors == 0 && gap_queue.size() == 0) begin
      $display("single_linkage_cluster_gap_tb passed");
    end else begin
      $display("single_linkage_cluster_gap_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/slcg_pkg.sv
sv/slcg_ctrl.sv
sv/slcg_dp.sv
sv/single_linkage_cluster_gap.sv
verif/single_linkage_cluster_gap_tb.sv
